>>> design/friend_graph_hop_search_defines.svh
// assertion macros shared by the friend graph hop search rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef FRIEND_GRAPH_HOP_SEARCH_DEFINES_SVH
`define FRIEND_GRAPH_HOP_SEARCH_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FHS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define FHS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fhs_pkg.sv
// shared constants, codes and controller/datapath handshake types
// no dependencies
`default_nettype none

package fhs_pkg;

    localparam int NODES      = 16;
    localparam int NODE_W     = 4;
    localparam int CNT_W      = 5;
    localparam int HOP_LEVELS = 3;
    localparam int DEPTH_W    = 2;
    localparam int SCAN_W     = 5;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int HOP_W      = 2;

    localparam logic [OP_W-1:0] OP_ADD_NODE = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL_EDGE = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    localparam logic [HOP_W-1:0] HOP_LIMIT_RESET = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic exec_emit;
        logic start_walk;
        logic walk_step;
        logic flush_emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic is_query;
        logic start_ok;
        logic found;
        logic pend_valid;
        logic at_root;
    } sts_t;

endpackage

`default_nettype wire

>>> design/friend_graph_hop_search.sv
// top level of the friend graph hop search block
// depends on fhs_pkg, fhs_ctrl and fhs_dp
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    s_op, s_node_a, s_node_b
//   m_        out        m_valid / m_ready    m_status, m_has_node, m_reached_node, m_last
//   cfg_      in         cfg_wr_en            cfg_wr_data (hop_limit)
//
// one request at a time: accept, decode in S_EXEC, then the result register
// node and edge requests: result loads from S_EXEC once the result register is free, then S_IDLE
// query: after S_EXEC the walk runs in S_WALK, and the last result loads in S_FLUSH;
//   unless stalled, one matrix row search per cycle picks the lowest unvisited neighbor
// aresetn is synchronous active low; it clears the matrix, node count and hop_limit to 3
// a stalled m_ channel holds the walk only when a second reached node must queue
`default_nettype none

module friend_graph_hop_search (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [fhs_pkg::HOP_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fhs_pkg::OP_W-1:0]      s_op,
    input  logic [fhs_pkg::NODE_W-1:0]    s_node_a,
    input  logic [fhs_pkg::NODE_W-1:0]    s_node_b,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fhs_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_has_node,
    output logic [fhs_pkg::NODE_W-1:0]    m_reached_node,
    output logic                          m_last
);
    import fhs_pkg::*;

    // controller commands and datapath status
    cmd_t cmd;
    sts_t sts;

    // state machine: decode, walk, final flush of the held node
    fhs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // graph, stack, marks and the output register
    fhs_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_op           (s_op),
        .s_node_a       (s_node_a),
        .s_node_b       (s_node_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_has_node     (m_has_node),
        .m_reached_node (m_reached_node),
        .m_last         (m_last),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

`default_nettype wire

>>> design/fhs_ctrl.sv
// sequencing state machine for the hop search
// depends on fhs_pkg
`default_nettype none

module fhs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  fhs_pkg::sts_t  sts,
    output fhs_pkg::cmd_t  cmd
);
    import fhs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       walk_stall;

    // a new node cannot go out while the held one is blocked
    assign walk_stall = sts.found && sts.pend_valid && !sts.out_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // no request is taken while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.is_query && sts.start_ok) begin
                    cmd.start_walk = 1'b1;
                    state_next     = S_WALK;
                end else if (sts.out_free) begin
                    cmd.exec_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_WALK: begin
                if (!walk_stall) begin
                    cmd.walk_step = 1'b1;
                    if (!sts.found && sts.at_root) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush_emit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> design/fhs_dp.sv
// graph storage, walk stack, visited marks and result register
// depends on fhs_pkg and friend_graph_hop_search_defines.svh
`default_nettype none

`include "friend_graph_hop_search_defines.svh"

module fhs_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fhs_pkg::HOP_W-1:0]         cfg_wr_data,
    input  logic [fhs_pkg::OP_W-1:0]          s_op,
    input  logic [fhs_pkg::NODE_W-1:0]        s_node_a,
    input  logic [fhs_pkg::NODE_W-1:0]        s_node_b,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fhs_pkg::STATUS_W-1:0]      m_status,
    output logic                              m_has_node,
    output logic [fhs_pkg::NODE_W-1:0]        m_reached_node,
    output logic                              m_last,
    input  fhs_pkg::cmd_t                     cmd,
    output fhs_pkg::sts_t                     sts
);
    import fhs_pkg::*;

    logic [HOP_W-1:0]    hop_limit_reg;
    logic [NODES-1:0]    adj_reg [NODES];
    logic [CNT_W-1:0]    node_count_reg;
    logic [NODES-1:0]    visited_reg;
    logic [OP_W-1:0]     op_reg;
    logic [NODE_W-1:0]   a_reg;
    logic [NODE_W-1:0]   b_reg;
    logic [NODE_W-1:0]   path_reg [HOP_LEVELS];
    logic [SCAN_W-1:0]   scan_reg [HOP_LEVELS];
    logic [DEPTH_W-1:0]  depth_reg;
    logic                pend_valid_reg;
    logic [NODE_W-1:0]   pend_node_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_has_node_reg;
    logic [NODE_W-1:0]   m_node_reg;
    logic                m_last_reg;

    logic                out_free;
    logic                a_ok;
    logic                b_ok;
    logic                table_full;
    logic                edge_write;
    logic [NODE_W-1:0]   cur_node;
    logic [SCAN_W-1:0]   cur_scan;
    logic [NODES-1:0]    cur_row;
    logic [NODES-1:0]    scan_mask;
    logic [NODES-1:0]    cand;
    logic                found;
    logic [NODE_W-1:0]   found_idx;
    logic [HOP_W-1:0]    limit;
    logic                push;
    logic [DEPTH_W-1:0]  depth_up;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic                emit_has;
    logic [NODE_W-1:0]   emit_node;
    logic                emit_last;

    assign out_free   = !m_valid_reg || m_ready;
    assign a_ok       = {1'b0, a_reg} < node_count_reg;
    assign b_ok       = {1'b0, b_reg} < node_count_reg;
    assign table_full = node_count_reg == CNT_W'(NODES);
    assign edge_write = cmd.exec_emit && a_ok && b_ok
                        && (op_reg == OP_ADD_EDGE || op_reg == OP_DEL_EDGE);

    // candidate neighbors of the node on top of the stack
    assign cur_node = path_reg[depth_reg];
    assign cur_scan = scan_reg[depth_reg];
    assign cur_row  = adj_reg[cur_node];

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            scan_mask[i] = SCAN_W'(i) >= cur_scan;
        end
    end

    assign cand  = cur_row & ~visited_reg & scan_mask;
    assign found = |cand;

    // lowest candidate index
    always_comb begin
        found_idx = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found_idx = NODE_W'(i);
            end
        end
    end

    assign limit    = (hop_limit_reg == '0) ? HOP_W'(1) : hop_limit_reg;
    assign push     = ({1'b0, depth_reg} + 3'd1) < {1'b0, limit};
    assign depth_up = depth_reg + DEPTH_W'(1);

    // result selection
    always_comb begin
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_has    = 1'b0;
        emit_node   = '0;
        emit_last   = 1'b1;
        if (cmd.exec_emit) begin
            emit = 1'b1;
            case (op_reg)
                OP_ADD_NODE: emit_status = table_full ? ST_FULL : ST_OK;
                OP_ADD_EDGE,
                OP_DEL_EDGE: emit_status = (a_ok && b_ok) ? ST_OK : ST_BAD_INDEX;
                OP_QUERY:    emit_status = ST_BAD_INDEX;
                default:     emit_status = ST_OK;
            endcase
        end else if (cmd.walk_step && found && pend_valid_reg) begin
            emit      = 1'b1;
            emit_has  = 1'b1;
            emit_node = pend_node_reg;
            emit_last = 1'b0;
        end else if (cmd.flush_emit) begin
            emit      = 1'b1;
            emit_has  = pend_valid_reg;
            emit_node = pend_valid_reg ? pend_node_reg : '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_limit_reg  <= HOP_LIMIT_RESET;
            node_count_reg <= '0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hop_limit_reg <= cfg_wr_data;
            end
            if (cmd.exec_emit && op_reg == OP_ADD_NODE && !table_full) begin
                node_count_reg <= node_count_reg + CNT_W'(1);
            end
            if (cmd.start_walk) begin
                visited_reg    <= NODES'(1) << a_reg;
                depth_reg      <= '0;
                pend_valid_reg <= 1'b0;
            end else if (cmd.walk_step) begin
                if (found) begin
                    visited_reg    <= visited_reg | (NODES'(1) << found_idx);
                    pend_valid_reg <= 1'b1;
                    if (push) begin
                        depth_reg <= depth_up;
                    end
                end else if (depth_reg != '0) begin
                    depth_reg <= depth_reg - DEPTH_W'(1);
                end
            end else if (cmd.flush_emit) begin
                pend_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // adjacency matrix, kept symmetric
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NODES; i++) begin
                adj_reg[i] <= '0;
            end
        end else if (edge_write) begin
            adj_reg[a_reg][b_reg] <= (op_reg == OP_ADD_EDGE);
            adj_reg[b_reg][a_reg] <= (op_reg == OP_ADD_EDGE);
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg <= s_op;
            a_reg  <= s_node_a;
            b_reg  <= s_node_b;
        end
        if (cmd.start_walk) begin
            path_reg[0] <= a_reg;
            scan_reg[0] <= '0;
        end else if (cmd.walk_step && found) begin
            scan_reg[depth_reg] <= {1'b0, found_idx} + SCAN_W'(1);
            pend_node_reg       <= found_idx;
            if (push) begin
                path_reg[depth_up] <= found_idx;
                scan_reg[depth_up] <= '0;
            end
        end
        if (emit) begin
            m_status_reg   <= emit_status;
            m_has_node_reg <= emit_has;
            m_node_reg     <= emit_node;
            m_last_reg     <= emit_last;
        end
    end

    assign sts.out_free   = out_free;
    assign sts.is_query   = op_reg == OP_QUERY;
    assign sts.start_ok   = a_ok;
    assign sts.found      = found;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.at_root    = depth_reg == '0;

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_has_node     = m_has_node_reg;
    assign m_reached_node = m_node_reg;
    assign m_last         = m_last_reg;

    `FHS_ASSERT_NOW(a_no_overwrite, aclk, aresetn, emit && m_valid_reg, m_ready, "result register overwritten while stalled")
    `FHS_ASSERT_NOW(a_no_start_report, aclk, aresetn, cmd.walk_step && found, found_idx != path_reg[0], "query start node reached again")
    `FHS_ASSERT_NEXT(a_visited_grows, aclk, aresetn, cmd.walk_step, (visited_reg & $past(visited_reg)) == $past(visited_reg), "visited mark lost during walk")
    `FHS_ASSERT_NOW(a_depth_bound, aclk, aresetn, 1'b1, depth_reg != 2'd3, "walk stack deeper than three levels")

endmodule

`default_nettype wire
